[hdl/ttl_pkg.sv]
`default_nettype none

package ttl_pkg;

    // fixed scaling of the front end
    localparam int unsigned ADC_FULL_SCALE = 16383;
    localparam int unsigned TABLE_POINTS   = 24;

    localparam logic [11:0] VREF_RESET = 12'd3300;
    localparam logic [15:0] V_TOP      = 16'd52800;   // 3.3 V in 1/16 mV
    localparam logic [14:0] R_SCALE    = 15'd32000;   // divider top resistor, 1/16 ohm
    localparam logic [11:0] T_MAX      = 12'd2400;    // 150 degC in 1/16 degC
    localparam logic [11:0] HYST       = 12'd8;

    localparam int unsigned TBL_IDX_W    = $clog2(TABLE_POINTS);
    localparam int unsigned SEARCH_STEPS = $clog2(TABLE_POINTS - 1);

    // shared serial divider geometry
    localparam int unsigned DIV_W = 16;
    localparam int unsigned QUO_W = 17;
    localparam int unsigned CNT_W = 5;

    // quotient bits needed by each of the three divisions
    localparam logic [CNT_W-1:0] DIV1_STEPS = 5'd17;
    localparam logic [CNT_W-1:0] DIV2_STEPS = 5'd16;
    localparam logic [CNT_W-1:0] DIV3_STEPS = 5'd9;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] rem_init;   // leading dividend bits, already below the divisor
        logic [QUO_W-1:0] dividend;   // remaining dividend bits, msb first
        logic [DIV_W-1:0] divisor;
        logic [CNT_W-1:0] count;
    } t_div_cmd;

    typedef struct packed {
        logic             busy;
        logic [QUO_W-1:0] quotient;
    } t_div_sts;

    // resistance points of the sensor curve, ohm
    function automatic logic [11:0] ohm_of(input logic [TBL_IDX_W-1:0] idx);
        logic [11:0] r;
        case (idx)
            5'd0:    r = 12'd490;
            5'd1:    r = 12'd515;
            5'd2:    r = 12'd567;
            5'd3:    r = 12'd624;
            5'd4:    r = 12'd684;
            5'd5:    r = 12'd747;
            5'd6:    r = 12'd815;
            5'd7:    r = 12'd886;
            5'd8:    r = 12'd961;
            5'd9:    r = 12'd1000;
            5'd10:   r = 12'd1040;
            5'd11:   r = 12'd1122;
            5'd12:   r = 12'd1209;
            5'd13:   r = 12'd1299;
            5'd14:   r = 12'd1392;
            5'd15:   r = 12'd1490;
            5'd16:   r = 12'd1591;
            5'd17:   r = 12'd1696;
            5'd18:   r = 12'd1805;
            5'd19:   r = 12'd1915;
            5'd20:   r = 12'd1970;
            5'd21:   r = 12'd2023;
            5'd22:   r = 12'd2124;
            default: r = 12'd2211;
        endcase
        return r;
    endfunction

    // temperature points of the sensor curve, degC
    function automatic logic signed [8:0] deg_of(input logic [TBL_IDX_W-1:0] idx);
        logic signed [8:0] d;
        case (idx)
            5'd0:    d = -9'sd55;
            5'd1:    d = -9'sd50;
            5'd2:    d = -9'sd40;
            5'd3:    d = -9'sd30;
            5'd4:    d = -9'sd20;
            5'd5:    d = -9'sd10;
            5'd6:    d = 9'sd0;
            5'd7:    d = 9'sd10;
            5'd8:    d = 9'sd20;
            5'd9:    d = 9'sd25;
            5'd10:   d = 9'sd30;
            5'd11:   d = 9'sd40;
            5'd12:   d = 9'sd50;
            5'd13:   d = 9'sd60;
            5'd14:   d = 9'sd70;
            5'd15:   d = 9'sd80;
            5'd16:   d = 9'sd90;
            5'd17:   d = 9'sd100;
            5'd18:   d = 9'sd110;
            5'd19:   d = 9'sd120;
            5'd20:   d = 9'sd125;
            5'd21:   d = 9'sd130;
            5'd22:   d = 9'sd140;
            default: d = 9'sd150;
        endcase
        return d;
    endfunction

    // table resistance in 1/16 ohm
    function automatic logic [15:0] ohm16(input logic [TBL_IDX_W-1:0] idx);
        return {ohm_of(idx), 4'b0000};
    endfunction

endpackage

`default_nettype wire

[hdl/ttl_if.sv]
`default_nettype none

// adc code channel
interface ttl_in_if;
    logic        valid;
    logic        ready;
    logic [13:0] adc_code;

    modport source (output valid, output adc_code, input ready);
    modport sink   (input valid, input adc_code, output ready);
endinterface

// temperature result channel
interface ttl_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] temperature;
    logic        updated;

    modport source (output valid, output temperature, output updated, input ready);
    modport sink   (input valid, input temperature, input updated, output ready);
endinterface

`default_nettype wire

[hdl/ttl_sdiv.sv]
`default_nettype none

// restoring divider, one quotient bit per cycle
module ttl_sdiv
    import ttl_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_cmd i_cmd,
    output t_div_sts      o_sts
);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_rem;
    logic [QUO_W-1:0] r_dvd;
    logic [DIV_W-1:0] r_dsr;
    logic [QUO_W-1:0] r_quo;

    logic [DIV_W+1:0] trial;
    logic             ge;
    logic [DIV_W-1:0] n_rem;

    always_comb begin
        trial = {1'b0, r_rem, r_dvd[QUO_W-1]} - {2'b00, r_dsr};
        ge    = ~trial[DIV_W+1];
        n_rem = ge ? trial[DIV_W-1:0] : {r_rem[DIV_W-2:0], r_dvd[QUO_W-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_cmd.start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_cmd.count;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rem <= i_cmd.rem_init;
            r_dvd <= i_cmd.dividend;
            r_dsr <= i_cmd.divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[QUO_W-2:0], 1'b0};
            r_quo <= {r_quo[QUO_W-2:0], ge};
        end
    end

    assign o_sts = '{busy: r_busy, quotient: r_quo};

endmodule

`default_nettype wire

[hdl/thermistor_temperature_linearizer_top.sv]
// Thermistor temperature linearizer.
// i_in carries one 14-bit ADC code of the divider node per transfer; o_out
// returns one result per code: the held temperature in 1/16 degC (0..2400)
// and a flag telling whether this code moved it by more than 0.5 degC.
// i_cfg_we / i_cfg_data write the 12-bit ADC reference in mV; write it only
// while no code is in flight.
// One code is processed at a time; i_in.ready is high only when the engine
// is free. Time from input transfer to o_out.valid depends on the path:
// shortest when the node is at or above 3.3 V, longer when the resistance
// quotient overflows 16 bits, longer again when the resistance falls outside
// the curve, and longest on the full interpolation path. i_in.ready rises
// with o_out.valid, so a new code is taken only once the last one is done.
// The work is done by one shared bit-serial divider that runs the voltage
// scaling (17 bits), the resistance division (16 bits) and the segment
// interpolation (9 bits), plus a 5-step binary search of the curve.
// Results wait in an output register; a stalled receiver holds the engine
// at its last step, and nothing is lost.
// Reset clears the held temperature to 0, loads 3300 mV as reference and
// empties the output register.
`default_nettype none

module thermistor_temperature_linearizer_top
    import ttl_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ttl_in_if.sink     i_in,
    ttl_out_if.source  o_out,
    input  wire logic  i_cfg_we,
    input  wire logic [11:0] i_cfg_data
);

    // sequencer codes
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ST1    = 4'd1;
    localparam logic [3:0] S_DIV1   = 4'd2;
    localparam logic [3:0] S_ST2    = 4'd3;
    localparam logic [3:0] S_DIV2   = 4'd4;
    localparam logic [3:0] S_SEARCH = 4'd5;
    localparam logic [3:0] S_PREP3  = 4'd6;
    localparam logic [3:0] S_ST3    = 4'd7;
    localparam logic [3:0] S_DIV3   = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    logic [3:0]           r_state, n_state;
    logic [11:0]          r_vref;
    logic [25:0]          r_prod, n_prod;       // code * vref
    logic [30:0]          r_num, n_num;         // 32000 * v
    logic [15:0]          r_den, n_den;         // 52800 - v
    logic [15:0]          r_r, n_r;             // resistance, 1/16 ohm
    logic [TBL_IDX_W-1:0] r_lo, n_lo;
    logic [TBL_IDX_W-1:0] r_hi, n_hi;
    logic [2:0]           r_step, n_step;
    logic [14:0]          r_num3, n_num3;       // dt * (R - r_left)
    logic [6:0]           r_dr, n_dr;           // r_right - r_left, ohm
    logic signed [8:0]    r_tl, n_tl;           // left temperature, degC
    logic [11:0]          r_t, n_t;             // new reading
    logic [11:0]          r_held, n_held;
    logic                 r_out_valid, n_out_valid;
    logic [11:0]          r_out_temp, n_out_temp;
    logic                 r_out_upd, n_out_upd;

    t_div_cmd div_cmd;
    t_div_sts div_sts;

    logic                 in_xfer;
    logic                 out_free;
    logic                 ovf2;
    logic [TBL_IDX_W:0]   mid_sum;
    logic [TBL_IDX_W-1:0] mid;
    logic [TBL_IDX_W-1:0] left;
    logic [15:0]          left_ohm16;
    logic [3:0]           dt;
    logic [10:0]          rdiff;
    logic signed [12:0]   t_full;
    logic [11:0]          diff;
    logic                 upd;

    ttl_sdiv u_sdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (div_cmd),
        .o_sts   (div_sts)
    );

    assign in_xfer  = i_in.valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || o_out.ready;

    // a resistance quotient beyond 16 bits is far above the curve
    assign ovf2 = {1'b0, r_num[30:16]} >= r_den;

    // binary search probe
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = mid_sum[TBL_IDX_W:1];

    // segment geometry, r_lo is the right end after the search
    assign left       = r_lo - 1'b1;
    assign left_ohm16 = ohm16(left);
    assign dt         = 4'(deg_of(r_lo) - deg_of(left));
    assign rdiff      = 11'(r_r - left_ohm16);

    assign t_full = $signed({r_tl, 4'b0000}) + $signed({5'b00000, div_sts.quotient[7:0]});

    // hysteresis against the held value
    assign diff = (r_t > r_held) ? (r_t - r_held) : (r_held - r_t);
    assign upd  = diff > HYST;

    // divider command, one job per start state
    always_comb begin
        div_cmd = '0;
        case (r_state)
            S_ST1: begin
                // v = (prod << 4) / full scale, leading 13 bits are below the divisor
                div_cmd.start    = 1'b1;
                div_cmd.rem_init = {3'b000, r_prod[25:13]};
                div_cmd.dividend = {r_prod[12:0], 4'b0000};
                div_cmd.divisor  = DIV_W'(ADC_FULL_SCALE);
                div_cmd.count    = DIV1_STEPS;
            end
            S_ST2: begin
                div_cmd.start    = !ovf2;
                div_cmd.rem_init = {1'b0, r_num[30:16]};
                div_cmd.dividend = {r_num[15:0], 1'b0};
                div_cmd.divisor  = r_den;
                div_cmd.count    = DIV2_STEPS;
            end
            S_ST3: begin
                // interpolation step stays below 2^9, so the top 6 bits are below dr
                div_cmd.start    = 1'b1;
                div_cmd.rem_init = {10'b0, r_num3[14:9]};
                div_cmd.dividend = {r_num3[8:0], 8'b0};
                div_cmd.divisor  = {9'b0, r_dr};
                div_cmd.count    = DIV3_STEPS;
            end
            default: begin
                div_cmd = '0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_prod      = r_prod;
        n_num       = r_num;
        n_den       = r_den;
        n_r         = r_r;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_step      = r_step;
        n_num3      = r_num3;
        n_dr        = r_dr;
        n_tl        = r_tl;
        n_t         = r_t;
        n_held      = r_held;
        n_out_valid = r_out_valid;
        n_out_temp  = r_out_temp;
        n_out_upd   = r_out_upd;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_prod  = 26'(i_in.adc_code) * 26'(r_vref);
                    n_state = S_ST1;
                end
            end
            S_ST1: begin
                n_state = S_DIV1;
            end
            S_DIV1: begin
                if (!div_sts.busy) begin
                    if (div_sts.quotient >= {1'b0, V_TOP}) begin
                        // node at or above 3.3 V
                        n_t     = T_MAX;
                        n_state = S_DONE;
                    end else begin
                        n_num   = 31'(R_SCALE) * 31'(div_sts.quotient[15:0]);
                        n_den   = V_TOP - div_sts.quotient[15:0];
                        n_state = S_ST2;
                    end
                end
            end
            S_ST2: begin
                if (ovf2) begin
                    n_t     = T_MAX;
                    n_state = S_DONE;
                end else begin
                    n_state = S_DIV2;
                end
            end
            S_DIV2: begin
                if (!div_sts.busy) begin
                    n_r = div_sts.quotient[15:0];
                    if (div_sts.quotient[15:0] >= ohm16(TBL_IDX_W'(TABLE_POINTS - 1))) begin
                        n_t     = T_MAX;
                        n_state = S_DONE;
                    end else if (div_sts.quotient[15:0] <= ohm16('0)) begin
                        // at or below the coldest point, clamps to 0
                        n_t     = '0;
                        n_state = S_DONE;
                    end else begin
                        n_lo    = TBL_IDX_W'(1);
                        n_hi    = TBL_IDX_W'(TABLE_POINTS - 1);
                        n_step  = '0;
                        n_state = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                // smallest index whose resistance is not below R
                if (r_r <= ohm16(mid)) begin
                    n_hi = mid;
                end else begin
                    n_lo = mid + 1'b1;
                end
                n_step = r_step + 1'b1;
                if (r_step == 3'(SEARCH_STEPS - 1)) begin
                    n_state = S_PREP3;
                end
            end
            S_PREP3: begin
                n_num3  = 15'(dt) * 15'(rdiff);
                n_dr    = 7'(ohm_of(r_lo) - ohm_of(left));
                n_tl    = deg_of(left);
                n_state = S_ST3;
            end
            S_ST3: begin
                n_state = S_DIV3;
            end
            S_DIV3: begin
                if (!div_sts.busy) begin
                    if (t_full < 0) begin
                        n_t = '0;
                    end else if (t_full > $signed({1'b0, T_MAX})) begin
                        n_t = T_MAX;
                    end else begin
                        n_t = t_full[11:0];
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_upd   = upd;
                    n_out_temp  = upd ? r_t : r_held;
                    if (upd) begin
                        n_held = r_t;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vref      <= VREF_RESET;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_held      <= n_held;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_vref <= i_cfg_data;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod     <= n_prod;
        r_num      <= n_num;
        r_den      <= n_den;
        r_r        <= n_r;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_step     <= n_step;
        r_num3     <= n_num3;
        r_dr       <= n_dr;
        r_tl       <= n_tl;
        r_t        <= n_t;
        r_out_temp <= n_out_temp;
        r_out_upd  <= n_out_upd;
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.temperature = r_out_temp;
    assign o_out.updated     = r_out_upd;

    // one code at a time: engine is busy right after an input transfer
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken while a code is in flight");

    // a pending result always shows the held temperature
    a_out_is_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.temperature == r_held))
        else $error("pending result differs from held temperature");

    // temperature stays within 0..150 degC
    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.temperature <= T_MAX))
        else $error("temperature above 150 degC");

    // held value only moves when a result is loaded with the update flag
    a_held_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held != $past(r_held)) |-> (o_out.valid && o_out.updated))
        else $error("held temperature changed without an update");

endmodule

`default_nettype wire

[tb/tb_thermistor_temperature_linearizer_top.sv]
`timescale 1ns / 1ps

module tb_thermistor_temperature_linearizer_top
    import ttl_pkg::*;
();

    // run length guard, far above the slowest legal run
    localparam int CYCLE_LIMIT = 500000;
    // cycles allowed for the engine to settle before a reference change
    localparam int SETTLE_CYCLES = 60;
    // receiver hold-off long enough to back the engine up into the input
    localparam int LONG_HOLD = 300;

    // node voltage (1/16 mV) at the bottom and top resistance of the curve
    localparam int V_CURVE_LO = 10390;
    localparam int V_CURVE_HI = 27722;

    typedef struct packed {
        logic [11:0] temperature;
        logic        updated;
    } t_temp_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [11:0] i_cfg_data;

    ttl_in_if  adc_if ();
    ttl_out_if temp_if ();

    thermistor_temperature_linearizer_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (adc_if),
        .o_out      (temp_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // sensor curve: degC against ohm
    int curve_deg [24];
    int curve_ohm [24];

    // shadow of the block state
    logic [11:0] vref_model;
    logic [11:0] held_model;

    logic [13:0]  adc_codes_q [$];      // codes waiting to be offered
    t_temp_result expected_temps [$];   // results owed by the block

    logic gaps_on;       // random idling on both sides when set
    int   src_wait;
    int   sink_wait;
    int   results_seen;
    int   long_holds;
    int   mismatches;
    int   cycle_count;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // code -> temperature in 1/16 degC, clamped to 0..150 degC
    function automatic logic [11:0] linearize_code(input logic [13:0] code,
                                                   input logic [11:0] vref);
        longint v;
        longint r;
        longint rl;
        longint rr;
        longint tl;
        longint tr;
        longint t;
        v = (longint'(code) * longint'(vref) * 16) / longint'(ADC_FULL_SCALE);
        // node at or above 3.3 V
        if (v >= 52800)
            return T_MAX;
        r = (64'sd32000 * v) / (64'sd52800 - v);
        // resistance off the top or the bottom of the curve
        if (r >= longint'(curve_ohm[23]) * 16)
            return T_MAX;
        if (r <= longint'(curve_ohm[0]) * 16)
            return 12'd0;
        for (int k = 0; k < 23; k++) begin
            rl = longint'(curve_ohm[k]) * 16;
            rr = longint'(curve_ohm[k + 1]) * 16;
            if (r > rl && r <= rr) begin
                tl = longint'(curve_deg[k]) * 16;
                tr = longint'(curve_deg[k + 1]) * 16;
                t  = tl + ((tr - tl) * (r - rl)) / (rr - rl);
                if (t < 0)
                    return 12'd0;
                if (t > longint'(T_MAX))
                    return T_MAX;
                return t[11:0];
            end
        end
        return T_MAX;
    endfunction

    // code span that lands on the curve for a given reference
    function automatic void curve_window(input logic [11:0] vref, output int lo,
                                         output int hi);
        if (vref == 0) begin
            lo = 0;
            hi = 16383;
        end else begin
            lo = (V_CURVE_LO * 16383) / (int'(vref) * 16);
            hi = (V_CURVE_HI * 16383) / (int'(vref) * 16);
            if (lo > 16383) lo = 16383;
            if (hi > 16383) hi = 16383;
        end
    endfunction

    // idle cycles before the next transfer on either side
    function automatic int draw_gap();
        if (!gaps_on || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 14);
    endfunction

    // mostly codes on the curve, small steps around the last code for the
    // hysteresis, plus full-range noise and the ends of the scale
    function automatic logic [13:0] pick_code(input logic [13:0] prev,
                                              input logic [11:0] vref);
        int lo;
        int hi;
        int sel;
        int c;
        curve_window(vref, lo, hi);
        lo  = (lo > 20) ? lo - 20 : 0;
        hi  = (hi < 16363) ? hi + 20 : 16383;
        sel = $urandom_range(0, 99);
        if (sel < 55) begin
            c = $urandom_range(lo, hi);
        end else if (sel < 75) begin
            c = int'(prev) + $urandom_range(0, 24) - 12;
            if (c < 0) c = 0;
            if (c > 16383) c = 16383;
        end else if (sel < 92) begin
            c = $urandom_range(0, 16383);
        end else begin
            case ($urandom_range(0, 3))
                0:       c = 0;
                1:       c = 16383;
                2:       c = lo;
                default: c = hi;
            endcase
        end
        return c[13:0];
    endfunction

    // reference change, only with the engine idle
    task automatic set_vref(input logic [11:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        vref_model = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // sender pause: everything offered, taken and answered, then settle
    task automatic wait_idle();
        @(negedge i_clk);
        while (adc_codes_q.size() != 0 || adc_if.valid || expected_temps.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic queue_random(input int count);
        logic [13:0] prev;
        prev = 14'd0;
        for (int k = 0; k < count; k++) begin
            prev = pick_code(prev, vref_model);
            adc_codes_q.push_back(prev);
        end
    endtask

    // input driver: one code per transfer, result predicted on acceptance
    always @(posedge i_clk) begin : adc_driver
        logic         nv;
        logic [13:0]  nc;
        logic [11:0]  t_new;
        int           delta;
        t_temp_result res;
        if (!i_rst_n) begin
            adc_if.valid    <= 1'b0;
            adc_if.adc_code <= '0;
            src_wait = 0;
        end else begin
            nv = adc_if.valid;
            nc = adc_if.adc_code;
            if (adc_if.valid && adc_if.ready) begin
                // hysteresis: the held value moves only on a change above 0.5 degC
                t_new = linearize_code(adc_if.adc_code, vref_model);
                delta = (t_new > held_model) ? int'(t_new - held_model)
                                             : int'(held_model - t_new);
                res.updated = (delta > int'(HYST));
                if (res.updated)
                    held_model = t_new;
                res.temperature = held_model;
                expected_temps.push_back(res);
                nv = 1'b0;
                src_wait = draw_gap();
            end
            if (!nv) begin
                if (src_wait > 0) begin
                    src_wait--;
                end else if (adc_codes_q.size() > 0) begin
                    nv = 1'b1;
                    nc = adc_codes_q.pop_front();
                end
            end
            adc_if.valid    <= nv;
            adc_if.adc_code <= nc;
        end
    end

    // result monitor: random ready, two long hold-offs, in-order compare
    always @(posedge i_clk) begin : temp_monitor
        t_temp_result want;
        if (!i_rst_n) begin
            temp_if.ready <= 1'b0;
            sink_wait = 0;
        end else begin
            if (temp_if.valid && temp_if.ready) begin
                results_seen++;
                if (expected_temps.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result temperature=%0d updated=%0b", $time,
                             temp_if.temperature, temp_if.updated);
                end else begin
                    want = expected_temps.pop_front();
                    if (temp_if.temperature !== want.temperature) begin
                        mismatches++;
                        $display("%0t: temperature expected %0d actual %0d", $time,
                                 want.temperature, temp_if.temperature);
                    end
                    if (temp_if.updated !== want.updated) begin
                        mismatches++;
                        $display("%0t: updated expected %0b actual %0b", $time,
                                 want.updated, temp_if.updated);
                    end
                end
                sink_wait = draw_gap();
                // stall the receiver while codes are still being offered
                if ((long_holds == 0 && results_seen >= 60 && adc_codes_q.size() >= 8) ||
                    (long_holds == 1 && results_seen >= 300 && adc_codes_q.size() >= 8)) begin
                    sink_wait = LONG_HOLD;
                    long_holds++;
                end
            end
            if (sink_wait > 0) begin
                sink_wait--;
                temp_if.ready <= 1'b0;
            end else begin
                temp_if.ready <= 1'b1;
            end
        end
    end

    // timeout guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int lo;
        int hi;
        curve_deg = '{-55, -50, -40, -30, -20, -10, 0, 10, 20, 25, 30, 40,
                      50, 60, 70, 80, 90, 100, 110, 120, 125, 130, 140, 150};
        curve_ohm = '{490, 515, 567, 624, 684, 747, 815, 886, 961, 1000, 1040, 1122,
                      1209, 1299, 1392, 1490, 1591, 1696, 1805, 1915, 1970, 2023, 2124, 2211};
        adc_if.valid    = 1'b0;
        adc_if.adc_code = '0;
        temp_if.ready   = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_data      = '0;
        i_rst_n         = 1'b0;
        vref_model      = VREF_RESET;
        held_model      = '0;
        gaps_on         = 1'b0;
        results_seen    = 0;
        long_holds      = 0;
        mismatches      = 0;
        cycle_count     = 0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed codes at the reset reference, back to back
        curve_window(vref_model, lo, hi);
        adc_codes_q = '{14'd0, 14'd16383, 14'd1, 14'd16382, 14'h2aaa, 14'h1555};
        // just below, on and just above the bottom and top of the curve
        adc_codes_q.push_back(14'(lo - 1));
        adc_codes_q.push_back(14'(lo));
        adc_codes_q.push_back(14'(lo + 1));
        adc_codes_q.push_back(14'(hi - 1));
        adc_codes_q.push_back(14'(hi));
        adc_codes_q.push_back(14'(hi + 1));
        // repeated and slowly drifting code around the hysteresis band
        adc_codes_q.push_back(14'd6000);
        adc_codes_q.push_back(14'd6000);
        adc_codes_q.push_back(14'd6002);
        adc_codes_q.push_back(14'd6010);
        adc_codes_q.push_back(14'd6030);
        // node at 3.3 V, held, then back to the bottom
        adc_codes_q.push_back(14'd16383);
        adc_codes_q.push_back(14'd16383);
        adc_codes_q.push_back(14'd0);
        wait_idle();

        // zero reference: every code reads 0
        set_vref(12'd0);
        gaps_on = 1'b1;
        adc_codes_q.push_back(14'd16383);
        adc_codes_q.push_back(14'd0);
        queue_random(8);
        wait_idle();

        // full reference: upper codes run past 3.3 V
        set_vref(12'd4095);
        queue_random(60);
        wait_idle();

        // low end of the usable range, no idling
        set_vref(12'd1000);
        gaps_on = 1'b0;
        queue_random(60);
        wait_idle();

        set_vref(12'd3600);
        gaps_on = 1'b1;
        queue_random(70);
        wait_idle();

        set_vref(12'($urandom_range(1000, 3600)));
        queue_random(60);
        wait_idle();

        // any 12-bit reference, odd ones included
        set_vref(12'($urandom_range(0, 4095)));
        queue_random(40);
        wait_idle();

        // back to the nominal reference for the longest stretch
        set_vref(VREF_RESET);
        queue_random(150);
        wait_idle();

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
